@@ rtl/dcrt_pkg.sv @@
// shared types, widths and codes of the datagram chunk reassembly tracker
// depends on nothing
package dcrt_pkg;

  localparam int SENDER_W = 48;
  localparam int ID_W = 64;
  localparam int CNT_W = 7;
  localparam int KIND_W = 32;
  localparam int TICK_W = 32;
  localparam int MAP_W = 64;
  localparam int MAX_CHUNKS = 64;
  localparam int DEF_TABLE_ENTRIES = 16;

  localparam logic [6:0] HDR_RESET = 7'd18;
  localparam logic [4:0] MAXPEND_RESET = 5'd8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    REG_HEADER_BYTES = 2'd0,
    REG_MAX_PENDING  = 2'd1,
    REG_TIMEOUT      = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    V_TOO_SMALL   = 4'd0,
    V_LEN_MISS    = 4'd1,
    V_PING        = 4'd2,
    V_EMPTY       = 4'd3,
    V_ZERO_COUNT  = 4'd4,
    V_TOO_MANY    = 4'd5,
    V_IDX_RANGE   = 4'd6,
    V_STORED      = 4'd7,
    V_DUPLICATE   = 4'd8,
    V_COMPLETE    = 4'd9
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [SENDER_W-1:0] sender;
    logic [ID_W-1:0]     message_id;
    logic [CNT_W-1:0]    total;
    logic [KIND_W-1:0]   kind;
    logic [TICK_W-1:0]   last_seen;
    logic [CNT_W-1:0]    received;
    logic [MAP_W-1:0]    piece_map;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/dcrt_ram.sv @@
// generic single write port ram with one registered read port
// depends on nothing
module dcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/datagram_chunk_reassembly_tracker_top.sv @@
// datagram chunk reassembly tracker: checks, prune/lookup scan, entry update
// depends on dcrt_pkg and dcrt_ram
//
// channel   signals                                             direction
// input     start, busy, datagram_bytes .. now_ticks            in, busy out
// result    done, verdict, entry_slot, kind_out, evicted,
//           pruned_count                                        out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data           in, ready out
//
// a header rejected by the checks gets done from the check state, with no scan
// a tracked header goes on through the scan and commit states: one ram read per slot
// during the scan, then the commit state updates and writes back the entry
// reset clears the slot valid flags and the config registers, no clearing pass
// the result strobe cannot be stalled; the config port is always ready
module datagram_chunk_reassembly_tracker_top #(
  parameter int TABLE_ENTRIES = dcrt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] datagram_bytes,
  input  logic [47:0] sender,
  input  logic [63:0] message_id,
  input  logic [15:0] piece_index,
  input  logic [15:0] piece_total,
  input  logic [15:0] declared_length,
  input  logic [31:0] message_kind,
  input  logic [31:0] now_ticks,
  output logic        done,
  output logic [3:0]  verdict,
  output logic [3:0]  entry_slot,
  output logic [31:0] kind_out,
  output logic        evicted,
  output logic [4:0]  pruned_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dcrt_pkg::*;

  localparam int N = TABLE_ENTRIES;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;

  state_t state, state_next;

  logic [6:0]  header_bytes;
  logic [4:0]  max_pending;
  logic [31:0] timeout;

  logic [15:0] r_dbytes, r_pidx, r_ptot, r_dlen;
  logic [47:0] r_sender;
  logic [63:0] r_id;
  logic [31:0] r_kind, r_now;

  logic [N-1:0] slot_valid;

  logic [IW:0]   rd_cnt;
  logic          proc_vld;
  logic [IW-1:0] proc_idx;
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  entry_t        rd_entry, wr_entry;

  logic [4:0]    pruned;
  logic [IW:0]   count;
  logic          hit;
  logic [IW-1:0] hit_idx;
  entry_t        hit_entry;
  logic          sold_vld, aold_vld, free_vld;
  logic [IW-1:0] sold_idx, aold_idx, free_idx;
  logic [31:0]   sold_age, aold_age;

  logic          early;
  verdict_t      early_verdict;
  logic          scan_last;

  logic [31:0] age;
  logic        smatch, live, stale;

  logic          evict_s, init, bit_set, complete, in_range;
  logic [IW-1:0] s;
  logic          evict_flag;
  logic [6:0]    tot, rec0, rec1;
  logic [63:0]   map0;
  logic [31:0]   kindv;
  verdict_t      cverdict;

  assign cfg_ready = 1'b1;

  dcrt_ram #(.WIDTH(ENTRY_W), .DEPTH(N)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // header checks
  always_comb begin
    early = 1'b1;
    early_verdict = V_TOO_SMALL;
    if (r_dbytes < {9'd0, header_bytes}) begin
      early_verdict = V_TOO_SMALL;
    end else if (r_dlen > r_dbytes - {9'd0, header_bytes}) begin
      early_verdict = V_LEN_MISS;
    end else if (r_kind == 32'd0 || r_kind == 32'd1) begin
      early_verdict = V_PING;
    end else if (r_dlen == 16'd0) begin
      early_verdict = V_EMPTY;
    end else if (r_ptot == 16'd0) begin
      early_verdict = V_ZERO_COUNT;
    end else if (17'(r_ptot) > 17'(MAX_CHUNKS)) begin
      early_verdict = V_TOO_MANY;
    end else begin
      early = 1'b0;
    end
  end

  assign scan_last = proc_vld && (proc_idx == IW'(N - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_CHECK;
      ST_CHECK:  state_next = early ? ST_IDLE : ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    ram_we = (state == ST_COMMIT);
    ram_raddr = rd_cnt[IW-1:0];
  end

  // per-slot scan evaluation
  assign age = r_now - rd_entry.last_seen;
  assign smatch = (rd_entry.sender == r_sender);
  assign stale = slot_valid[proc_idx] && smatch && (age > timeout);
  assign live = slot_valid[proc_idx] && !stale;

  // slot choice and entry update
  always_comb begin
    evict_s = !hit && (CW'(count) >= CW'(max_pending)) && sold_vld;
    evict_flag = 1'b0;
    init = 1'b1;
    if (hit) begin
      s = hit_idx;
      init = (hit_entry.total != r_ptot[6:0]) || (hit_entry.kind != r_kind);
    end else if (evict_s) begin
      s = (free_vld && free_idx < sold_idx) ? free_idx : sold_idx;
      evict_flag = 1'b1;
    end else if (free_vld) begin
      s = free_idx;
    end else begin
      s = aold_vld ? aold_idx : '0;
      evict_flag = 1'b1;
    end
    tot   = init ? r_ptot[6:0] : hit_entry.total;
    map0  = init ? 64'd0 : hit_entry.piece_map;
    rec0  = init ? 7'd0 : hit_entry.received;
    kindv = init ? r_kind : hit_entry.kind;
    in_range = r_pidx < {9'd0, tot};
    bit_set = map0[r_pidx[5:0]];
    rec1 = rec0;
    complete = 1'b0;
    cverdict = V_IDX_RANGE;
    wr_entry.sender = r_sender;
    wr_entry.message_id = r_id;
    wr_entry.total = tot;
    wr_entry.kind = kindv;
    wr_entry.last_seen = r_now;
    wr_entry.received = rec0;
    wr_entry.piece_map = map0;
    if (in_range) begin
      rec1 = bit_set ? rec0 : rec0 + 7'd1;
      wr_entry.piece_map = map0 | (64'd1 << r_pidx[5:0]);
      wr_entry.received = rec1;
      complete = (rec1 == tot);
      cverdict = complete ? V_COMPLETE : (bit_set ? V_DUPLICATE : V_STORED);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      header_bytes <= HDR_RESET;
      max_pending <= MAXPEND_RESET;
      timeout <= TIMEOUT_RESET;
      slot_valid <= '0;
      done <= 1'b0;
      proc_vld <= 1'b0;
      rd_cnt <= '0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_HEADER_BYTES: header_bytes <= cfg_data[6:0];
          REG_MAX_PENDING:  max_pending <= cfg_data[4:0];
          REG_TIMEOUT:      timeout <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          rd_cnt <= '0;
          proc_vld <= 1'b0;
        end
        ST_CHECK: begin
          if (early) begin
            done <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (rd_cnt < (IW + 1)'(N)) begin
            proc_vld <= 1'b1;
            proc_idx <= rd_cnt[IW-1:0];
            rd_cnt <= rd_cnt + 1'b1;
          end else begin
            proc_vld <= 1'b0;
          end
          if (stale && proc_vld) begin
            slot_valid[proc_idx] <= 1'b0;
          end
        end
        ST_COMMIT: begin
          done <= 1'b1;
          proc_vld <= 1'b0;
          if (evict_s) begin
            slot_valid[sold_idx] <= 1'b0;
          end
          slot_valid[s] <= !complete;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      r_dbytes <= datagram_bytes;
      r_sender <= sender;
      r_id <= message_id;
      r_pidx <= piece_index;
      r_ptot <= piece_total;
      r_dlen <= declared_length;
      r_kind <= message_kind;
      r_now <= now_ticks;
    end
    if (state == ST_CHECK) begin
      pruned <= '0;
      count <= '0;
      hit <= 1'b0;
      sold_vld <= 1'b0;
      aold_vld <= 1'b0;
      free_vld <= 1'b0;
      verdict <= early_verdict;
      entry_slot <= '0;
      kind_out <= (early_verdict == V_PING || early_verdict == V_EMPTY) ? r_kind : '0;
      evicted <= 1'b0;
      pruned_count <= '0;
    end
    if (state == ST_SCAN && proc_vld) begin
      if (stale && pruned != 5'd31) begin
        pruned <= pruned + 5'd1;
      end
      if (!live && !free_vld) begin
        free_vld <= 1'b1;
        free_idx <= proc_idx;
      end
      if (live) begin
        if (smatch) begin
          count <= count + 1'b1;
          if (!hit && rd_entry.message_id == r_id) begin
            hit <= 1'b1;
            hit_idx <= proc_idx;
            hit_entry <= rd_entry;
          end
          if (!sold_vld || age > sold_age) begin
            sold_vld <= 1'b1;
            sold_idx <= proc_idx;
            sold_age <= age;
          end
        end
        if (!aold_vld || age > aold_age) begin
          aold_vld <= 1'b1;
          aold_idx <= proc_idx;
          aold_age <= age;
        end
      end
    end
    if (state == ST_COMMIT) begin
      verdict <= cverdict;
      entry_slot <= in_range ? 4'(s) : 4'd0;
      kind_out <= complete ? kindv : 32'd0;
      evicted <= evict_flag;
      pruned_count <= pruned;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for datagram_chunk_reassembly_tracker_top
// depends on dcrt_pkg and the tracker rtl; a scoreboard class predicts each verdict
`timescale 1ns / 100ps

module tb;
  import dcrt_pkg::*;

  typedef struct {
    bit [15:0] dbytes;
    bit [47:0] snd;
    bit [63:0] id;
    bit [15:0] idx;
    bit [15:0] tot;
    bit [15:0] dlen;
    bit [31:0] kind;
    bit [31:0] now;
  } datagram_t;

  typedef struct {
    verdict_t  v;
    bit [3:0]  slot;
    bit [31:0] kind;
    bit        ev;
    bit [4:0]  pruned;
  } verdict_rec_t;

  class reassembly_scoreboard;
    bit [6:0]  hdr_len = HDR_RESET;
    bit [4:0]  max_pend = MAXPEND_RESET;
    bit [31:0] timeout = TIMEOUT_RESET;
    bit        live[16];
    bit [47:0] owner[16];
    bit [63:0] msg[16];
    bit [6:0]  total[16];
    bit [31:0] kind_of[16];
    bit [31:0] seen[16];
    bit [6:0]  got[16];
    bit [63:0] pieces[16];
    verdict_rec_t awaited[$];
    int errors = 0;

    function void write_reg(reg_index_t idx, bit [31:0] data);
      case (idx)
        REG_HEADER_BYTES: hdr_len = data[6:0];
        REG_MAX_PENDING:  max_pend = data[4:0];
        REG_TIMEOUT:      timeout = data;
        default: ;
      endcase
    endfunction

    function int oldest(bit only_snd, bit [47:0] s, bit [31:0] now);
      int best;
      bit [31:0] best_age, age;
      best = -1;
      best_age = 0;
      for (int i = 0; i < 16; i++) begin
        age = now - seen[i];
        if (live[i] && (!only_snd || owner[i] == s) && (best < 0 || age > best_age)) begin
          best = i;
          best_age = age;
        end
      end
      return best;
    endfunction

    function void open_slot(int s, datagram_t d);
      live[s] = 1;
      owner[s] = d.snd;
      msg[s] = d.id;
      total[s] = d.tot[6:0];
      kind_of[s] = d.kind;
      got[s] = 0;
      pieces[s] = 0;
    endfunction

    function void note_datagram(datagram_t d);
      verdict_rec_t o;
      int s, count, victim;
      o.v = V_TOO_SMALL;
      o.slot = 0;
      o.kind = 0;
      o.ev = 0;
      o.pruned = 0;
      s = -1;
      count = 0;
      if (d.dbytes < hdr_len) o.v = V_TOO_SMALL;
      else if (d.dlen > d.dbytes - hdr_len) o.v = V_LEN_MISS;
      else if (d.kind == 0 || d.kind == 1) begin
        o.v = V_PING;
        o.kind = d.kind;
      end else if (d.dlen == 0) begin
        o.v = V_EMPTY;
        o.kind = d.kind;
      end else if (d.tot == 0) o.v = V_ZERO_COUNT;
      else if (d.tot > MAX_CHUNKS) o.v = V_TOO_MANY;
      else begin
        for (int i = 0; i < 16; i++)
          if (live[i] && owner[i] == d.snd && bit'(32'(d.now - seen[i]) > timeout)) begin
            live[i] = 0;
            o.pruned++;
          end
        for (int i = 0; i < 16; i++)
          if (live[i] && owner[i] == d.snd) begin
            count++;
            if (s < 0 && msg[i] == d.id) s = i;
          end
        if (s < 0) begin
          if (count >= max_pend) begin
            victim = oldest(1, d.snd, d.now);
            if (victim >= 0) begin
              live[victim] = 0;
              o.ev = 1;
            end
          end
          for (int i = 0; i < 16; i++)
            if (s < 0 && !live[i]) s = i;
          if (s < 0) begin
            s = oldest(0, 0, d.now);
            if (s < 0) s = 0;
            o.ev = 1;
          end
          open_slot(s, d);
        end else if (total[s] != d.tot || kind_of[s] != d.kind) begin
          open_slot(s, d);
        end
        seen[s] = d.now;
        if (d.idx >= total[s]) o.v = V_IDX_RANGE;
        else begin
          o.slot = s[3:0];
          if (!pieces[s][d.idx]) begin
            pieces[s][d.idx] = 1;
            got[s] = got[s] + 7'd1;
            o.v = V_STORED;
          end else o.v = V_DUPLICATE;
          if (got[s] == total[s]) begin
            o.v = V_COMPLETE;
            o.kind = kind_of[s];
            live[s] = 0;
          end
        end
      end
      awaited.push_back(o);
    endfunction

    function void check_result(logic [3:0] v, logic [3:0] slot, logic [31:0] kind,
                               logic ev, logic [4:0] pruned);
      verdict_rec_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected: verdict %0d", v);
        return;
      end
      e = awaited.pop_front();
      if (v !== e.v || slot !== e.slot || kind !== e.kind || ev !== e.ev
          || pruned !== e.pruned) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp v=%0d slot=%0d kind=%h ev=%0d pr=%0d,",
                    " got v=%0d slot=%0d kind=%h ev=%0d pr=%0d"},
                   e.v, e.slot, e.kind, e.ev, e.pruned, v, slot, kind, ev, pruned);
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, done, evicted, cfg_valid, cfg_ready;
  logic [15:0] datagram_bytes, piece_index, piece_total, declared_length;
  logic [47:0] sender;
  logic [63:0] message_id;
  logic [31:0] message_kind, now_ticks, kind_out, cfg_data;
  logic [3:0]  verdict, entry_slot;
  logic [4:0]  pruned_count;
  logic [1:0]  cfg_index;

  reassembly_scoreboard sb = new;
  bit        calm = 0;
  bit [31:0] tick = 0;
  bit [47:0] sender_pool[6];
  bit [63:0] id_base;

  datagram_chunk_reassembly_tracker_top dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(verdict, entry_slot, kind_out, evicted, pruned_count);
  end

  task automatic send(datagram_t d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    datagram_bytes <= d.dbytes;
    sender <= d.snd;
    message_id <= d.id;
    piece_index <= d.idx;
    piece_total <= d.tot;
    declared_length <= d.dlen;
    message_kind <= d.kind;
    now_ticks <= d.now;
    do @(posedge clk); while (busy);
    sb.note_datagram(d);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, bit [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic datagram_t mk(bit [15:0] db, bit [47:0] s, bit [63:0] id, bit [15:0] ix,
                                   bit [15:0] tt, bit [15:0] dl, bit [31:0] k, bit [31:0] n);
    datagram_t d;
    d = '{db, s, id, ix, tt, dl, k, n};
    return d;
  endfunction

  function automatic datagram_t random_datagram();
    datagram_t d;
    bit [2:0] m;
    if ($urandom_range(0, 9) == 0) begin
      d = mk(16'($urandom), 48'({$urandom, $urandom}), {$urandom, $urandom},
             16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 1)) d.tot = 16'($urandom_range(0, 70));
      return d;
    end
    if ($urandom_range(0, 49) == 0) tick += sb.timeout + $urandom_range(1, 5);
    else tick += $urandom_range(0, 3);
    m = 3'($urandom_range(0, 7));
    d.snd = sender_pool[$urandom_range(0, 5)];
    d.id = id_base ^ 64'(m);
    d.tot = (m == 7) ? 16'd64 : (m == 6) ? 16'd20 : 16'(m % 5 + 1);
    d.kind = 32'h100 + m;
    if ($urandom_range(0, 32) == 0) d.tot = 16'($urandom_range(1, 64));
    if ($urandom_range(0, 32) == 0) d.kind = $urandom_range(0, 4);
    d.idx = ($urandom_range(0, 19) == 0) ? 16'(d.tot + $urandom_range(0, 2))
                                         : 16'($urandom_range(0, d.tot - 1));
    d.dlen = 16'($urandom_range(1, 200));
    d.dbytes = 16'(sb.hdr_len + d.dlen + $urandom_range(0, 50));
    if ($urandom_range(0, 29) == 0) d.dlen = $urandom_range(0, 3) == 0 ? 16'd0 : d.dbytes;
    d.now = tick;
    return d;
  endfunction

  initial begin
    bit [47:0] a, b;
    bit [31:0] settings[6][3];
    rst = 1;
    start = 0;
    cfg_valid = 0;
    cfg_index = REG_HEADER_BYTES;
    cfg_data = 0;
    datagram_bytes = 0;
    sender = 0;
    message_id = 0;
    piece_index = 0;
    piece_total = 0;
    declared_length = 0;
    message_kind = 0;
    now_ticks = 0;
    settings = '{'{18, 8, 1000}, '{0, 1, 0}, '{64, 16, 32'hffffffff}, '{127, 0, 50},
                 '{5, 31, 200}, '{18, 3, 20}};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    a = 48'h0a00_0001_1f90;
    b = 48'hc0a8_0102_0035;
    // size and header checks
    send(mk(17, a, 1, 0, 2, 0, 5, 10));
    send(mk(18, a, 1, 0, 2, 1, 5, 10));
    send(mk(100, a, 1, 0, 2, 10, 0, 10));
    send(mk(100, a, 1, 0, 2, 10, 1, 10));
    send(mk(100, a, 1, 0, 2, 0, 5, 10));
    send(mk(100, a, 1, 0, 0, 10, 5, 10));
    send(mk(100, a, 1, 0, 65, 10, 5, 10));
    send(mk(100, a, 1, 0, 16'hffff, 10, 5, 10));
    // out of range, store, duplicate, total and kind mismatch, complete
    send(mk(100, a, 1, 3, 2, 10, 5, 11));
    send(mk(100, a, 1, 0, 2, 10, 5, 12));
    send(mk(100, a, 1, 0, 2, 10, 5, 13));
    send(mk(100, a, 1, 0, 3, 10, 5, 14));
    send(mk(100, a, 1, 1, 3, 10, 6, 15));
    send(mk(100, a, 2, 0, 1, 10, 5, 16));
    send(mk(16'hffff, 48'hffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 63, 64, 16'hffed,
            32'hffff_ffff, 32'hffff_ffff));
    // stale prune, then per-sender eviction
    send(mk(100, a, 3, 0, 2, 10, 5, 3000));
    for (int i = 0; i < 9; i++) send(mk(100, b, 64'(i + 10), 0, 4, 10, 7, 32'(3000 + i)));
    drain();

    foreach (settings[p]) begin
      if (p > 0) begin
        write_reg(REG_HEADER_BYTES, settings[p][0]);
        write_reg(REG_MAX_PENDING, settings[p][1]);
        write_reg(REG_TIMEOUT, settings[p][2]);
        if (p == 1) write_reg(REG_UNUSED, 32'hffff_ffff);
      end
      foreach (sender_pool[i]) sender_pool[i] = 48'({$urandom, $urandom});
      id_base = {$urandom, $urandom};
      if (p == 2) tick = 32'hffff_ff00;
      for (int n = 0; n < 330; n++) begin
        calm = (p == 5 && n > 150);
        if (p == 3 && n == 160) drain();
        send(random_datagram());
      end
      drain();
    end

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ datagram_chunk_reassembly_tracker_top.f @@
rtl/dcrt_pkg.sv
rtl/dcrt_ram.sv
rtl/datagram_chunk_reassembly_tracker_top.sv
tb/sv/tb.sv
